### hw/rtl/medw_pkg.sv
// Shared types and constants for the 3x3 morphology window block.
package medw_pkg;

    localparam int KERNEL_SIZE = 3;
    localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PIX_W       = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [PIX_W-1:0]       PIX_FULL          = 8'd255;
    localparam logic [PIX_W-1:0]       PIX_ZERO          = 8'd0;
    localparam logic [KERNEL_TAPS-1:0] KERNEL_MASK_RESET = 9'd186;
    localparam int                     WIDTH_RESET       = 640;
    localparam int                     HEIGHT_RESET      = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KERNEL_MASK  = 3'd0,
        REG_DILATE_MODE  = 3'd1,
        REG_BINARY_MODE  = 3'd2,
        REG_IMAGE_WIDTH  = 3'd3,
        REG_IMAGE_HEIGHT = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             drain;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] result_value;
        logic             frame_last;
    } pixel_out_t;

    typedef struct packed {
        logic [KERNEL_TAPS-1:0] kernel_mask;
        logic                   dilate_mode;
        logic                   binary_mode;
    } medw_mode_t;

    // Per-result window control: taps that are enabled and inside the image,
    // whether any enabled tap falls outside, and the result flags.
    typedef struct packed {
        logic [KERNEL_TAPS-1:0] used;
        logic                   miss;
        logic                   emit;
        logic                   last;
    } medw_win_ctl_t;

    // Element 0 is the top row of the column, element 2 the bottom row.
    typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] medw_column_t;

endpackage

### hw/rtl/medw_ctrl.sv
// Configuration registers and raster position counters for the window block.
module medw_ctrl
    import medw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      accept,
    input  logic                      drain,
    output logic                      issue,
    output logic [$clog2(MAX_WIDTH)-1:0] issue_col,
    output medw_win_ctl_t             issue_ctl,
    output logic                      input_done,
    output medw_mode_t                mode
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int OROW_W = $clog2(MAX_HEIGHT);

    localparam logic [COL_W-1:0] W_LAST_RESET =
        COL_W'((WIDTH_RESET > MAX_WIDTH ? MAX_WIDTH : WIDTH_RESET) - 1);
    localparam logic [OROW_W-1:0] H_LAST_RESET =
        OROW_W'((HEIGHT_RESET > MAX_HEIGHT ? MAX_HEIGHT : HEIGHT_RESET) - 1);

    function automatic logic [COL_W-1:0] width_last(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) return '0;
        if (32'(v) > 32'(MAX_WIDTH)) return COL_W'(MAX_WIDTH - 1);
        return COL_W'(v - 1'b1);
    endfunction

    function automatic logic [OROW_W-1:0] height_last(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) return '0;
        if (32'(v) > 32'(MAX_HEIGHT)) return OROW_W'(MAX_HEIGHT - 1);
        return OROW_W'(v - 1'b1);
    endfunction

    logic [KERNEL_TAPS-1:0] mask_reg, mask_next;
    logic                   dilate_reg, dilate_next;
    logic                   binary_reg, binary_next;
    logic [COL_W-1:0]       w_last_reg, w_last_next;
    logic [OROW_W-1:0]      h_last_reg, h_last_next;
    logic [COL_W-1:0]       in_col_reg, in_col_next;
    logic [ROW_W-1:0]       in_row_reg, in_row_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic [OROW_W-1:0]      out_row_reg, out_row_next;

    logic                   restart;
    logic                   emit;
    logic                   last;
    logic                   col_wrap;
    logic                   out_col_wrap;
    logic [KERNEL_SIZE-1:0] row_ok;
    logic [KERNEL_SIZE-1:0] col_ok;
    logic [KERNEL_TAPS-1:0] in_range;

    always_comb
    begin
        input_done   = in_row_reg > ROW_W'(h_last_reg);
        issue        = accept && !(drain && !input_done);
        // The first result appears once the item one row and one pixel past
        // the first pixel has arrived.
        emit         = (in_row_reg > ROW_W'(1)) || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        col_wrap     = in_col_reg == w_last_reg;
        out_col_wrap = out_col_reg == w_last_reg;
        last         = out_col_wrap && (out_row_reg == h_last_reg);

        row_ok = {out_row_reg != h_last_reg, 1'b1, out_row_reg != '0};
        col_ok = {out_col_reg != w_last_reg, 1'b1, out_col_reg != '0};
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            for (int j = 0; j < KERNEL_SIZE; j++)
            begin
                in_range[i*KERNEL_SIZE + j] = row_ok[i] & col_ok[j];
            end
        end

        issue_col      = in_col_reg;
        issue_ctl.used = mask_reg & in_range;
        issue_ctl.miss = |(mask_reg & ~in_range);
        issue_ctl.emit = emit;
        issue_ctl.last = last;

        mode.kernel_mask = mask_reg;
        mode.dilate_mode = dilate_reg;
        mode.binary_mode = binary_reg;
    end

    always_comb
    begin
        mask_next    = mask_reg;
        dilate_next  = dilate_reg;
        binary_next  = binary_reg;
        w_last_next  = w_last_reg;
        h_last_next  = h_last_reg;
        restart      = 1'b0;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_KERNEL_MASK:  mask_next   = cfg_data[KERNEL_TAPS-1:0];
                REG_DILATE_MODE:  dilate_next = cfg_data[0];
                REG_BINARY_MODE:  binary_next = cfg_data[0];
                REG_IMAGE_WIDTH:
                begin
                    w_last_next = width_last(cfg_data);
                    restart     = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    h_last_next = height_last(cfg_data);
                    restart     = 1'b1;
                end
                default: ;
            endcase
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (issue)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (emit)
            begin
                priority if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= KERNEL_MASK_RESET;
            dilate_reg  <= 1'b0;
            binary_reg  <= 1'b0;
            w_last_reg  <= W_LAST_RESET;
            h_last_reg  <= H_LAST_RESET;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            mask_reg    <= mask_next;
            dilate_reg  <= dilate_next;
            binary_reg  <= binary_next;
            w_last_reg  <= w_last_next;
            h_last_reg  <= h_last_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

### hw/rtl/medw_line_buf.sv
// Line memory holding the two previous rows per column, with read-modify-write forwarding.
module medw_line_buf
    import medw_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         issue,
    input  logic [$clog2(MAX_WIDTH)-1:0] issue_col,
    input  logic [PIX_W-1:0]             issue_pixel,
    input  logic                         advance,
    output medw_column_t                 column
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    // Each entry holds {pixel two rows up, pixel one row up} for its column.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic [COL_W-1:0]   b_col_reg;
    logic [PIX_W-1:0]   b_pixel_reg;
    logic [2*PIX_W-1:0] entry;
    logic [2*PIX_W-1:0] wr_data;

    always_comb
    begin
        entry     = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        column[0] = entry[2*PIX_W-1:PIX_W];
        column[1] = entry[PIX_W-1:0];
        column[2] = b_pixel_reg;
        wr_data   = {entry[PIX_W-1:0], b_pixel_reg};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_mem[b_col_reg] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg  <= line_mem[issue_col];
            fwd_data_reg <= wr_data;
            b_col_reg    <= issue_col;
            b_pixel_reg  <= issue_pixel;
        end
    end

    // A read that meets the write-back of the same column in the same cycle sees
    // stale data, so the written value is kept and used instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (issue)
        begin
            fwd_hit_reg <= advance && (b_col_reg == issue_col);
        end
    end

endmodule

### hw/rtl/medw_window.sv
// Column shift window, min/max or binary reduction and output register.
module medw_window
    import medw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          issue,
    input  medw_win_ctl_t issue_ctl,
    input  medw_mode_t    mode,
    input  medw_column_t  column,
    input  logic          out_stall,
    output logic          advance,
    output logic          hold,
    output logic          b_valid,
    output logic          out_valid,
    output pixel_out_t    out_data
);

    logic          b_valid_reg, b_valid_next;
    logic          out_valid_reg, out_valid_next;
    medw_win_ctl_t b_ctl_reg;
    medw_column_t  left_reg;
    medw_column_t  center_reg;
    pixel_out_t    out_data_reg;

    logic [KERNEL_TAPS-1:0][PIX_W-1:0] taps;
    logic [KERNEL_TAPS-1:0]            tap_set;
    logic [PIX_W-1:0]                  neutral;
    logic [PIX_W-1:0]                  val;
    logic [PIX_W-1:0]                  acc;
    logic                              all_set;
    logic                              any_set;
    logic [PIX_W-1:0]                  result;

    assign hold    = b_valid_reg && b_ctl_reg.emit && out_valid_reg && out_stall;
    assign advance = b_valid_reg && !hold;
    assign b_valid = b_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        for (int i = 0; i < KERNEL_SIZE; i++)
        begin
            taps[i*KERNEL_SIZE + 0] = left_reg[i];
            taps[i*KERNEL_SIZE + 1] = center_reg[i];
            taps[i*KERNEL_SIZE + 2] = column[i];
        end
        for (int k = 0; k < KERNEL_TAPS; k++)
        begin
            tap_set[k] = taps[k] == PIX_FULL;
        end

        // Unused and outside taps take the value that leaves min or max alone.
        neutral = mode.dilate_mode ? PIX_ZERO : PIX_FULL;
        acc     = b_ctl_reg.used[0] ? taps[0] : neutral;
        for (int k = 1; k < KERNEL_TAPS; k++)
        begin
            val = b_ctl_reg.used[k] ? taps[k] : neutral;
            if (mode.dilate_mode)
            begin
                acc = (val > acc) ? val : acc;
            end
            else
            begin
                acc = (val < acc) ? val : acc;
            end
        end

        // In binary erosion an enabled tap outside the image counts as unset.
        all_set = !b_ctl_reg.miss && (&(~b_ctl_reg.used | tap_set));
        any_set = |(b_ctl_reg.used & tap_set);

        if (mode.binary_mode)
        begin
            result = (mode.dilate_mode ? any_set : all_set) ? PIX_FULL : PIX_ZERO;
        end
        else
        begin
            result = acc;
        end
    end

    always_comb
    begin
        priority if (issue)
        begin
            b_valid_next = 1'b1;
        end
        else if (advance)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end

        priority if (advance && b_ctl_reg.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_ctl_reg <= issue_ctl;
        end
        if (advance)
        begin
            left_reg   <= center_reg;
            center_reg <= column;
        end
        if (advance && b_ctl_reg.emit)
        begin
            out_data_reg.result_value <= result;
            out_data_reg.frame_last   <= b_ctl_reg.last;
        end
    end

endmodule

### hw/rtl/morphology_erode_dilate_window.sv
// Top level of the streaming 3x3 morphological erosion/dilation window.
// Throughput is one item per cycle unless the output stalls: the line memory does one read
// and one write-back per item. Pixel m's result reaches the output register when the item at
// raster position m + W + 1 advances; drain items after the frame push the last results out.
// Reset clears the control and counters and loads the register defaults; the line memory
// is not cleared, since every entry is written in a frame before it is used.
module morphology_erode_dilate_window
    import medw_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pixel_in_t             in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pixel_out_t            out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic             accept;
    logic             cfg_write;
    logic             issue;
    logic [COL_W-1:0] issue_col;
    medw_win_ctl_t    issue_ctl;
    logic             input_done;
    medw_mode_t       mode;
    medw_column_t     column;
    logic             advance;
    logic             hold;
    logic             b_valid;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign in_stall  = hold;
    assign accept    = in_valid && !in_stall;

    medw_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .drain      (in_data.drain),
        .issue      (issue),
        .issue_col  (issue_col),
        .issue_ctl  (issue_ctl),
        .input_done (input_done),
        .mode       (mode)
    );

    medw_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .issue_col   (issue_col),
        .issue_pixel (in_data.pixel_value),
        .advance     (advance),
        .column      (column)
    );

    medw_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_ctl (issue_ctl),
        .mode      (mode),
        .column    (column),
        .out_stall (out_stall),
        .advance   (advance),
        .hold      (hold),
        .b_valid   (b_valid),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    // The input side only waits behind a result that the output cannot yet take.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // A new result only appears after the window stage moved an item on.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance))
        else $error("result appeared without window stage advancing");

    // A drain transaction inside the frame must not enter the pipeline.
    a_drain_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.drain && !input_done) |=> !b_valid)
        else $error("drain inside the frame entered the window stage");
`endif

endmodule
